[rtl/i8d4rq_pkg.sv]
// Shared types and constants for the four-row int8 dot product with requantization.
// No dependencies; imported by every module of the block.
package i8d4rq_pkg;

    localparam int LANES           = 4;
    localparam int SUM_W           = 32;
    localparam int MULT_W          = 31;
    localparam int SHIFT_W         = 6;
    localparam int QUEUE_DEPTH_DEF = 2;

    typedef enum logic [1:0] {
        REG_ACT_ZERO_ADJ = 2'd0,
        REG_RES_ZERO_PT  = 2'd1,
        REG_ACT_MIN      = 2'd2,
        REG_ACT_MAX      = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic signed [8:0] act_zero_adj;
        logic signed [7:0] res_zero_pt;
        logic signed [7:0] act_min;
        logic signed [7:0] act_max;
    } cfg_t;

    // One finished column run, handed from the accumulator to the requantizer
    typedef struct packed {
        logic [LANES-1:0][SUM_W-1:0] row_sum;
        logic [SUM_W-1:0]            weight_sum;
        logic [SUM_W-1:0]            bias;
        logic [MULT_W-1:0]           multiplier;
        logic signed [SHIFT_W-1:0]   shift;
    } job_t;

endpackage

[rtl/int8_dot4_requantize.sv]
// Top level of the four-row int8 dot product with per-channel requantization.
// Holds the configuration registers; instantiates i8d4rq_front, i8d4rq_queue, i8d4rq_back.
//
// Usage:
//   Input channel (in_valid/in_ready): one weight and four activations per transfer,
//   plus bias, multiplier, shift and last. Items without last are taken one per cycle
//   and only accumulate. An item with last closes the run and queues it.
//   Output channel (out_valid/out_ready): four int8 results per finished run.
//   Config channel (cfg_valid/cfg_ready): cfg_ready is always high; index 0 input
//   offset, 1 output offset, 2 act_min, 3 act_max. Write only while the block is idle.
// Requantizer: it leaves idle, applies the offset correction, then for each row runs
//   shift, high multiply, round and clamp, and then loads the output register once
//   that register is free. It takes the next run only after loading the output
//   register, so the job queue absorbs runs meanwhile.
// Reset clears the sums, the queue and the output valid flag, and sets the registers
//   to offsets 0, act_min -128, act_max 127.
// Output stall: the result holds in the output register; the requantizer finishes the
//   next run and waits, then the queue fills and a last item is held off by in_ready.
module int8_dot4_requantize import i8d4rq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [7:0]         weight,
    input  logic signed [7:0]         act0,
    input  logic signed [7:0]         act1,
    input  logic signed [7:0]         act2,
    input  logic signed [7:0]         act3,
    input  logic signed [SUM_W-1:0]   bias,
    input  logic [MULT_W-1:0]         multiplier,
    input  logic signed [SHIFT_W-1:0] shift,
    input  logic                      last,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [7:0]         out0,
    output logic signed [7:0]         out1,
    output logic signed [7:0]         out2,
    output logic signed [7:0]         out3,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [1:0]                cfg_index,
    input  logic [8:0]                cfg_data
);

    cfg_t cfg_reg;
    job_t push_job;
    job_t head;
    logic push;
    logic pop;
    logic queue_full;
    logic queue_empty;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.act_zero_adj <= '0;
            cfg_reg.res_zero_pt  <= '0;
            cfg_reg.act_min      <= -8'sd128;
            cfg_reg.act_max      <= 8'sd127;
        end
        else if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_ACT_ZERO_ADJ: cfg_reg.act_zero_adj <= cfg_data;
                REG_RES_ZERO_PT:  cfg_reg.res_zero_pt  <= cfg_data[7:0];
                REG_ACT_MIN:      cfg_reg.act_min      <= cfg_data[7:0];
                REG_ACT_MAX:      cfg_reg.act_max      <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    i8d4rq_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .weight     (weight),
        .act0       (act0),
        .act1       (act1),
        .act2       (act2),
        .act3       (act3),
        .bias       (bias),
        .multiplier (multiplier),
        .shift      (shift),
        .last       (last),
        .queue_full (queue_full),
        .push       (push),
        .push_job   (push_job)
    );

    i8d4rq_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .full     (queue_full),
        .empty    (queue_empty)
    );

    i8d4rq_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job         (head),
        .queue_empty (queue_empty),
        .pop         (pop),
        .cfg         (cfg_reg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out0        (out0),
        .out1        (out1),
        .out2        (out2),
        .out3        (out3)
    );

endmodule

[rtl/i8d4rq_front.sv]
// Front end: accepts items, accumulates four row sums and the weight sum.
// Pushes a finished run into the job queue on the last item. Uses i8d4rq_pkg.
module i8d4rq_front import i8d4rq_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [7:0]         weight,
    input  logic signed [7:0]         act0,
    input  logic signed [7:0]         act1,
    input  logic signed [7:0]         act2,
    input  logic signed [7:0]         act3,
    input  logic [SUM_W-1:0]          bias,
    input  logic [MULT_W-1:0]         multiplier,
    input  logic signed [SHIFT_W-1:0] shift,
    input  logic                      last,
    input  logic                      queue_full,
    output logic                      push,
    output job_t                      push_job
);

    logic [LANES-1:0][SUM_W-1:0] row_sum_reg;
    logic [LANES-1:0][SUM_W-1:0] row_sum_next;
    logic [SUM_W-1:0]            wsum_reg;
    logic [SUM_W-1:0]            wsum_next;
    logic signed [7:0]           act [LANES];
    logic signed [15:0]          prod [LANES];
    logic                        accept;

    assign act[0] = act0;
    assign act[1] = act1;
    assign act[2] = act2;
    assign act[3] = act3;

    // only a last item needs room in the queue
    assign in_ready = !queue_full || !last;
    assign accept   = in_valid && in_ready;
    assign push     = accept && last;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            prod[i]         = weight * act[i];
            row_sum_next[i] = row_sum_reg[i] + SUM_W'(prod[i]);
        end
        wsum_next = wsum_reg + SUM_W'(weight);
    end

    always_comb
    begin
        push_job.row_sum    = row_sum_next;
        push_job.weight_sum = wsum_next;
        push_job.bias       = bias;
        push_job.multiplier = multiplier;
        push_job.shift      = shift;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_sum_reg <= '0;
            wsum_reg    <= '0;
        end
        else if (accept)
        begin
            if (last)
            begin
                // run handed off, start the next one from zero
                row_sum_reg <= '0;
                wsum_reg    <= '0;
            end
            else
            begin
                row_sum_reg <= row_sum_next;
                wsum_reg    <= wsum_next;
            end
        end
    end

endmodule

[rtl/i8d4rq_queue.sv]
// Short job queue between the accumulator front end and the requantizer.
// Holds finished runs as job_t entries. Uses i8d4rq_pkg.
module i8d4rq_queue import i8d4rq_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t head,
    output logic full,
    output logic empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t          mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

[rtl/i8d4rq_back.sv]
// Back end: requantizes one queued run lane by lane and drives the output register.
// Offset product, shift, Q31 high multiply, rounding shift, clamp. Uses i8d4rq_pkg.
module i8d4rq_back import i8d4rq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  job_t              job,
    input  logic              queue_empty,
    output logic              pop,
    input  cfg_t              cfg,
    output logic              out_valid,
    input  logic              out_ready,
    output logic signed [7:0] out0,
    output logic signed [7:0] out1,
    output logic signed [7:0] out2,
    output logic signed [7:0] out3
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_CORR = 6'b000010,
        S_SHL  = 6'b000100,
        S_MUL  = 6'b001000,
        S_RND  = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

    localparam int LW = $clog2(LANES);

    state_t               state_reg;
    state_t               state_next;
    logic [LW-1:0]        lane_reg;
    logic [SUM_W-1:0]     corr_reg;
    logic [SUM_W-1:0]     shl_reg;
    logic signed [63:0]   prod_reg;
    logic signed [7:0]    res_reg [LANES];
    logic                 out_valid_reg;
    logic signed [7:0]    out_reg [LANES];

    logic [SUM_W-1:0]     acc;
    logic [4:0]           left;
    logic [5:0]           right;
    logic signed [63:0]   rsum;
    logic signed [32:0]   h;
    logic signed [32:0]   r;
    logic [32:0]          mask;
    logic [32:0]          rem;
    logic [32:0]          thr;
    logic signed [32:0]   rnd;
    logic signed [31:0]   o;
    logic signed [31:0]   clamped;
    logic                 load_out;

    assign left  = job.shift[SHIFT_W-1] ? 5'd0 : job.shift[4:0];
    assign right = job.shift[SHIFT_W-1] ? 6'(-job.shift) : 6'd0;
    assign acc   = job.row_sum[lane_reg] + corr_reg;

    // rounding doubling high multiply, then round-half-away right shift, then clamp
    always_comb
    begin
        rsum = prod_reg + (64'sd1 <<< 30);
        h    = rsum[63:31];
        r    = h >>> right;
        mask = (33'd1 << right) - 33'd1;
        rem  = h & mask;
        thr  = (mask >> 1) + {32'd0, r[32]};
        rnd  = (rem > thr) ? r + 33'sd1 : r;
        o    = rnd[31:0] + 32'(cfg.res_zero_pt);
        clamped = o;
        if (clamped < 32'(cfg.act_min))
            clamped = 32'(cfg.act_min);
        if (clamped > 32'(cfg.act_max))
            clamped = 32'(cfg.act_max);
    end

    assign load_out = (state_reg == S_OUT) && (!out_valid_reg || out_ready);
    assign pop      = load_out;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (!queue_empty) state_next = S_CORR;
            S_CORR: state_next = S_SHL;
            S_SHL:  state_next = S_MUL;
            S_MUL:  state_next = S_RND;
            S_RND:  state_next = (lane_reg == LW'(LANES - 1)) ? S_OUT : S_SHL;
            S_OUT:  if (load_out) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lane_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CORR)
                lane_reg <= '0;
            else if (state_reg == S_RND)
                lane_reg <= lane_reg + 1'b1;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_CORR: corr_reg <= SUM_W'(job.weight_sum * SUM_W'(cfg.act_zero_adj)) + job.bias;
            S_SHL:  shl_reg  <= acc << left;
            S_MUL:  prod_reg <= $signed(shl_reg) * $signed({1'b0, job.multiplier});
            S_RND:  res_reg[lane_reg] <= clamped[7:0];
            default: ;
        endcase
        if (load_out)
        begin
            for (int i = 0; i < LANES; i++)
                out_reg[i] <= res_reg[i];
        end
    end

    assign out_valid = out_valid_reg;
    assign out0      = out_reg[0];
    assign out1      = out_reg[1];
    assign out2      = out_reg[2];
    assign out3      = out_reg[3];

endmodule
